// File: hw/rtl/vec3_arithmetic_unit_assert.svh
// assertion macros for the vector arithmetic unit
`ifndef VEC3_ARITHMETIC_UNIT_ASSERT_SVH
`define VEC3_ARITHMETIC_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define VAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// condition holds at every clock edge out of reset
`define VAU_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define VAU_ASSERT_IMP(lbl, ante, cons, msg)
`define VAU_ASSERT_ALWAYS(lbl, expr, msg)
`endif

`endif

// File: hw/rtl/vau_pkg.sv
// shared types, constants and helpers for the vector arithmetic unit
`timescale 1ns / 1ps
package vau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // internal widths
  localparam int MW = WORD_BITS + 1;       // multiplier operand
  localparam int PW = 2 * MW;              // product
  localparam int LW = PW + 1;              // lane sum of two products
  localparam int SW = LW + 2;              // sum of three lanes
  localparam int XW = SW + 1;              // rounding headroom
  localparam int RW = WORD_BITS + 3;       // square root remainder
  localparam int NW = WORD_BITS + FRAC_BITS; // divide numerator

  localparam logic signed [MW-1:0] ONE_FX = MW'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_SCALE = 4'd2,
    OP_DIV   = 4'd3,
    OP_NEG   = 4'd4,
    OP_DOT   = 4'd5,
    OP_CROSS = 4'd6,
    OP_MAG   = 4'd7,
    OP_NORM  = 4'd8,
    OP_LERP  = 4'd9
  } op_e;

  typedef logic [WORD_BITS-1:0]        word_t;
  typedef logic signed [WORD_BITS-1:0] sword_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic [3:0] opcode;
    sword_t     ax;
    sword_t     ay;
    sword_t     az;
    sword_t     bx;
    sword_t     by;
    sword_t     bz;
    sword_t     scalar_k;
  } in_item_t;

  typedef struct packed {
    sword_t rx;
    sword_t ry;
    sword_t rz;
    sword_t scalar_out;
    logic   div_zero;
    logic   saturated;
  } out_item_t;

  // side payload that rides along the root and quotient stages
  typedef struct packed {
    logic [3:0]  op;
    word_t [2:0] abs_a;
    logic [2:0]  qneg;
    word_t       dvs;
    logic        k_zero;
    logic        neg_k;
    word_t [2:0] vec;
    word_t       scl;
    logic        dz;
    logic        sat;
    logic [2:0]  ovf;
  } mid_t;

  typedef struct packed {
    word_t val;
    logic  flag;
  } sat_t;

  // drop fraction bits, round to nearest with ties away from zero
  function automatic logic signed [XW-1:0] round_frac(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] half;
    logic signed [XW-1:0] neg;
    logic signed [XW-1:0] t;
    half = '0;
    half[FRAC_BITS-1] = 1'b1;
    neg = '0;
    neg[0] = v[XW-1];
    t = v + half - neg;
    return t >>> FRAC_BITS;
  endfunction

  // clamp to the signed word range
  function automatic sat_t sat_word(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    sat_t r;
    hi = '0;
    hi[WORD_BITS-2:0] = '1;
    lo = '1;
    lo[WORD_BITS-2:0] = '0;
    if (v > hi) begin
      r.val = WORD_MAX;
      r.flag = 1'b1;
    end else if (v < lo) begin
      r.val = WORD_MIN;
      r.flag = 1'b1;
    end else begin
      r.val = v[WORD_BITS-1:0];
      r.flag = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/vec3_arithmetic_unit.sv
// three-component Q16.16 vector arithmetic unit, top level
//
// Input beats on in_valid/in_ready carry an opcode, vectors a and b and a
// scalar k; every input beat yields exactly one output beat on
// out_valid/out_ready with the result vector, a scalar, and the divide-by-zero
// and saturation flags. Unused opcodes return all zeros.
// The path from accepted input beat to out_valid runs through five front
// stages (operand select, multiply, lane combine, sum, dot rounding), 32
// square root stages, one divisor select stage, 32 divide stages and the
// output register. Every operation takes the same path.
// Throughput is one beat per cycle while the output is not stalled; the root
// and divide units are fully pipelined with one result bit per stage.
// Synchronous active-low reset empties the pipeline; payload is not cleared.
// When the receiver stalls, the whole pipeline holds and in_ready drops only
// while the output register is full and not taken; bubbles keep moving in
// the meantime since in_ready stays high while the output is empty.
`timescale 1ns / 1ps
`include "vec3_arithmetic_unit_assert.svh"
module vec3_arithmetic_unit import vau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic                   en;
  logic                   e_valid;
  logic [2*WORD_BITS-1:0] e_rad;
  mid_t                   e_mid;
  logic                   q_valid;
  word_t                  q_root;
  mid_t                   q_mid;
  logic                   o_valid;
  word_t [2:0]            o_quo;
  mid_t                   o_mid;

  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;
  word_t     lim   [3];
  word_t     qmag  [3];
  logic      qsat  [3];
  sword_t    qval  [3];

  // global advance: move when the output register is free or being drained
  assign en = ~out_valid_r | out_ready;
  assign in_ready = en;

  vau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_item  (in_item),
    .e_valid  (e_valid),
    .e_rad    (e_rad),
    .e_mid    (e_mid)
  );

  vau_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .s_valid (e_valid),
    .s_rad   (e_rad),
    .s_mid   (e_mid),
    .q_valid (q_valid),
    .q_root  (q_root),
    .q_mid   (q_mid)
  );

  vau_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .d_valid (q_valid),
    .d_root  (q_root),
    .d_mid   (q_mid),
    .o_valid (o_valid),
    .o_quo   (o_quo),
    .o_mid   (o_mid)
  );

  // quotient clamp and final result select
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lim[i]  = o_mid.qneg[i] ? WORD_MIN : WORD_MAX;
      qsat[i] = o_mid.ovf[i] || (o_quo[i] > lim[i]);
      qmag[i] = qsat[i] ? lim[i] : o_quo[i];
      qval[i] = o_mid.qneg[i] ? sword_t'(-qmag[i]) : sword_t'(qmag[i]);
    end
    out_item_nxt = '0;
    if (o_mid.op inside {OP_DIV, OP_NORM}) begin
      if (o_mid.dz) begin
        out_item_nxt.div_zero = 1'b1;
      end else begin
        out_item_nxt.rx = qval[0];
        out_item_nxt.ry = qval[1];
        out_item_nxt.rz = qval[2];
        out_item_nxt.saturated = qsat[0] | qsat[1] | qsat[2];
      end
    end else begin
      out_item_nxt.rx = o_mid.vec[0];
      out_item_nxt.ry = o_mid.vec[1];
      out_item_nxt.rz = o_mid.vec[2];
      out_item_nxt.scalar_out = o_mid.scl;
      out_item_nxt.saturated = o_mid.sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= o_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  `VAU_ASSERT_IMP(a_dz_clears, out_valid && out_item.div_zero, out_item.rx == '0 && out_item.ry == '0 && out_item.rz == '0 && out_item.scalar_out == '0 && !out_item.saturated, "div_zero beat with nonzero result")
  `VAU_ASSERT_ALWAYS(a_one_kind, !out_valid || out_item.scalar_out == '0 || (out_item.rx == '0 && out_item.ry == '0 && out_item.rz == '0), "scalar and vector result both nonzero")

endmodule

// File: hw/rtl/vau_front.sv
// operand select, multiply, lane combine, sum and dot rounding stages
`timescale 1ns / 1ps
module vau_front import vau_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  in_item_t               in_item,
  output logic                   e_valid,
  output logic [2*WORD_BITS-1:0] e_rad,
  output mid_t                   e_mid
);

  sword_t av [3];
  sword_t bv [3];
  logic signed [MW-1:0] ae [3];
  logic signed [MW-1:0] be [3];
  logic signed [MW-1:0] ke;
  logic signed [MW-1:0] omk;

  logic va_r, vb_r, vc_r, vd_r, ve_r;
  logic signed [MW-1:0] x_a_r [3], x_a_nxt [3];
  logic signed [MW-1:0] y_a_r [3], y_a_nxt [3];
  logic signed [MW-1:0] u_a_r [3], u_a_nxt [3];
  logic signed [MW-1:0] w_a_r [3], w_a_nxt [3];
  logic signed [MW-1:0] ev_a_r [3], ev_a_nxt [3];
  logic sub_a_r, sub_a_nxt;
  mid_t mid_a_r, mid_a_nxt;

  logic signed [PW-1:0] p_b_r [3], p_b_nxt [3];
  logic signed [PW-1:0] q_b_r [3], q_b_nxt [3];
  logic signed [MW-1:0] ev_b_r [3];
  logic sub_b_r;
  mid_t mid_b_r;

  logic signed [LW-1:0] l_c_r [3], l_c_nxt [3];
  logic signed [MW-1:0] ev_c_r [3];
  mid_t mid_c_r;

  logic signed [SW-1:0] sum_d_r, sum_d_nxt;
  mid_t mid_d_r, mid_d_nxt;
  sat_t lane_s [3];

  logic [2*WORD_BITS-1:0] rad_e_r, rad_e_nxt;
  mid_t mid_e_r, mid_e_nxt;
  sat_t dot_s;

  // stage a: decode and pick multiplier operands
  always_comb begin
    av[0] = in_item.ax;
    av[1] = in_item.ay;
    av[2] = in_item.az;
    bv[0] = in_item.bx;
    bv[1] = in_item.by;
    bv[2] = in_item.bz;
    ke = MW'(in_item.scalar_k);
    omk = ONE_FX - ke;
    mid_a_nxt = '0;
    mid_a_nxt.op = in_item.opcode;
    mid_a_nxt.dvs = in_item.scalar_k[WORD_BITS-1] ? word_t'(-in_item.scalar_k)
                                                   : word_t'(in_item.scalar_k);
    mid_a_nxt.k_zero = (in_item.scalar_k == '0);
    mid_a_nxt.neg_k = in_item.scalar_k[WORD_BITS-1];
    sub_a_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ae[i] = MW'(av[i]);
      be[i] = MW'(bv[i]);
      mid_a_nxt.abs_a[i] = av[i][WORD_BITS-1] ? word_t'(-av[i]) : word_t'(av[i]);
      mid_a_nxt.qneg[i] = av[i][WORD_BITS-1];
      x_a_nxt[i] = '0;
      y_a_nxt[i] = '0;
      u_a_nxt[i] = '0;
      w_a_nxt[i] = '0;
      ev_a_nxt[i] = '0;
    end
    case (in_item.opcode)
      OP_ADD: for (int i = 0; i < 3; i++) ev_a_nxt[i] = ae[i] + be[i];
      OP_SUB: for (int i = 0; i < 3; i++) ev_a_nxt[i] = ae[i] - be[i];
      OP_NEG: for (int i = 0; i < 3; i++) ev_a_nxt[i] = -ae[i];
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          x_a_nxt[i] = ae[i];
          y_a_nxt[i] = ke;
        end
      end
      OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          x_a_nxt[i] = ae[i];
          y_a_nxt[i] = be[i];
        end
      end
      OP_CROSS: begin
        sub_a_nxt = 1'b1;
        x_a_nxt[0] = ae[1]; y_a_nxt[0] = be[2]; u_a_nxt[0] = ae[2]; w_a_nxt[0] = be[1];
        x_a_nxt[1] = ae[2]; y_a_nxt[1] = be[0]; u_a_nxt[1] = ae[0]; w_a_nxt[1] = be[2];
        x_a_nxt[2] = ae[0]; y_a_nxt[2] = be[1]; u_a_nxt[2] = ae[1]; w_a_nxt[2] = be[0];
      end
      OP_MAG, OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          x_a_nxt[i] = ae[i];
          y_a_nxt[i] = ae[i];
        end
      end
      OP_LERP: begin
        for (int i = 0; i < 3; i++) begin
          x_a_nxt[i] = ae[i];
          y_a_nxt[i] = omk;
          u_a_nxt[i] = be[i];
          w_a_nxt[i] = ke;
        end
      end
      default: ;
    endcase
  end

  // stage b: products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_b_nxt[i] = PW'(x_a_r[i]) * PW'(y_a_r[i]);
      q_b_nxt[i] = PW'(u_a_r[i]) * PW'(w_a_r[i]);
    end
  end

  // stage c: combine the two products of each lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      l_c_nxt[i] = sub_b_r ? LW'(p_b_r[i]) - LW'(q_b_r[i]) : LW'(p_b_r[i]) + LW'(q_b_r[i]);
    end
  end

  // stage d: lane sum plus clamped vector results, rounded where they come from products
  always_comb begin
    sum_d_nxt = SW'(l_c_r[0]) + SW'(l_c_r[1]) + SW'(l_c_r[2]);
    mid_d_nxt = mid_c_r;
    for (int i = 0; i < 3; i++) begin
      lane_s[i] = '0;
      if (mid_c_r.op inside {OP_ADD, OP_SUB, OP_NEG}) begin
        lane_s[i] = sat_word(XW'(ev_c_r[i]));
      end else if (mid_c_r.op inside {OP_SCALE, OP_CROSS, OP_LERP}) begin
        lane_s[i] = sat_word(round_frac(XW'(l_c_r[i])));
      end
      mid_d_nxt.vec[i] = lane_s[i].val;
    end
    mid_d_nxt.sat = lane_s[0].flag | lane_s[1].flag | lane_s[2].flag;
  end

  // stage e: dot product result and square root radicand
  always_comb begin
    mid_e_nxt = mid_d_r;
    rad_e_nxt = sum_d_r[2*WORD_BITS-1:0];
    dot_s = sat_word(round_frac(XW'(sum_d_r)));
    if (mid_d_r.op == OP_DOT) begin
      mid_e_nxt.scl = dot_s.val;
      mid_e_nxt.sat = dot_s.flag;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        x_a_r[i]  <= x_a_nxt[i];
        y_a_r[i]  <= y_a_nxt[i];
        u_a_r[i]  <= u_a_nxt[i];
        w_a_r[i]  <= w_a_nxt[i];
        ev_a_r[i] <= ev_a_nxt[i];
        p_b_r[i]  <= p_b_nxt[i];
        q_b_r[i]  <= q_b_nxt[i];
        ev_b_r[i] <= ev_a_r[i];
        l_c_r[i]  <= l_c_nxt[i];
        ev_c_r[i] <= ev_b_r[i];
      end
      sub_a_r <= sub_a_nxt;
      mid_a_r <= mid_a_nxt;
      sub_b_r <= sub_a_r;
      mid_b_r <= mid_a_r;
      mid_c_r <= mid_b_r;
      sum_d_r <= sum_d_nxt;
      mid_d_r <= mid_d_nxt;
      rad_e_r <= rad_e_nxt;
      mid_e_r <= mid_e_nxt;
    end
  end

  assign e_valid = ve_r;
  assign e_rad   = rad_e_r;
  assign e_mid   = mid_e_r;

endmodule

// File: hw/rtl/vau_sqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module vau_sqrt import vau_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   s_valid,
  input  logic [2*WORD_BITS-1:0] s_rad,
  input  mid_t                   s_mid,
  output logic                   q_valid,
  output word_t                  q_root,
  output mid_t                   q_mid
);

  logic [RW-1:0]          rem_r  [WORD_BITS];
  logic [RW-1:0]          rem_nxt[WORD_BITS];
  logic [RW-1:0]          rem_p  [WORD_BITS];
  word_t                  root_r  [WORD_BITS];
  word_t                  root_nxt[WORD_BITS];
  word_t                  root_p  [WORD_BITS];
  logic [2*WORD_BITS-1:0] rad_r  [WORD_BITS];
  logic [2*WORD_BITS-1:0] rad_p  [WORD_BITS];
  logic [RW-1:0]          cur    [WORD_BITS];
  logic [RW-1:0]          trial  [WORD_BITS];
  mid_t                   mid_r  [WORD_BITS];
  logic                   vld_r  [WORD_BITS];

  // stage inputs: first stage from the port, the rest from the stage before
  always_comb begin
    rem_p[0]  = '0;
    root_p[0] = '0;
    rad_p[0]  = s_rad;
    for (int g = 1; g < WORD_BITS; g++) begin
      rem_p[g]  = rem_r[g-1];
      root_p[g] = root_r[g-1];
      rad_p[g]  = rad_r[g-1];
    end
  end

  // one trial subtract per stage
  always_comb begin
    for (int g = 0; g < WORD_BITS; g++) begin
      cur[g]   = {rem_p[g][RW-3:0], rad_p[g][2*WORD_BITS-1 -: 2]};
      trial[g] = RW'({root_p[g], 2'b01});
      if (cur[g] >= trial[g]) begin
        rem_nxt[g]  = cur[g] - trial[g];
        root_nxt[g] = {root_p[g][WORD_BITS-2:0], 1'b1};
      end else begin
        rem_nxt[g]  = cur[g];
        root_nxt[g] = {root_p[g][WORD_BITS-2:0], 1'b0};
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < WORD_BITS; g++) vld_r[g] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= s_valid;
      for (int g = 1; g < WORD_BITS; g++) vld_r[g] <= vld_r[g-1];
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      mid_r[0] <= s_mid;
      for (int g = 1; g < WORD_BITS; g++) mid_r[g] <= mid_r[g-1];
      for (int g = 0; g < WORD_BITS; g++) begin
        rem_r[g]  <= rem_nxt[g];
        root_r[g] <= root_nxt[g];
        rad_r[g]  <= rad_p[g] << 2;
      end
    end
  end

  assign q_valid = vld_r[WORD_BITS-1];
  assign q_root  = root_r[WORD_BITS-1];
  assign q_mid   = mid_r[WORD_BITS-1];

endmodule

// File: hw/rtl/vau_div.sv
// divisor select and three-lane pipelined divider, one quotient bit per stage
`timescale 1ns / 1ps
module vau_div import vau_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        d_valid,
  input  word_t       d_root,
  input  mid_t        d_mid,
  output logic        o_valid,
  output word_t [2:0] o_quo,
  output mid_t        o_mid
);

  // prep stage
  logic          pv_r;
  mid_t          pm_r, pm_nxt;
  word_t         pdv_r, pdv_nxt;
  word_t         prem_r [3], prem_nxt [3];
  word_t         plo_r  [3], plo_nxt  [3];
  logic [NW-1:0] num [3];

  // divide stages
  logic  vld_r [WORD_BITS];
  mid_t  mid_r [WORD_BITS];
  word_t dv_r  [WORD_BITS];
  word_t dv_p  [WORD_BITS];
  word_t rem_r   [WORD_BITS][3];
  word_t rem_nxt [WORD_BITS][3];
  word_t rem_p   [WORD_BITS][3];
  word_t lo_r    [WORD_BITS][3];
  word_t lo_nxt  [WORD_BITS][3];
  word_t lo_p    [WORD_BITS][3];
  logic [WORD_BITS:0] cur [WORD_BITS][3];

  // divisor, zero check, magnitude result and rounded numerators
  always_comb begin
    pm_nxt = d_mid;
    pdv_nxt = (d_mid.op == OP_NORM) ? d_root : d_mid.dvs;
    case (d_mid.op)
      OP_DIV: begin
        pm_nxt.dz = d_mid.k_zero;
        for (int i = 0; i < 3; i++) pm_nxt.qneg[i] = d_mid.qneg[i] ^ d_mid.neg_k;
      end
      OP_NORM: pm_nxt.dz = (d_root == '0);
      OP_MAG: begin
        pm_nxt.scl = d_root[WORD_BITS-1] ? WORD_MAX : d_root;
        pm_nxt.sat = d_root[WORD_BITS-1];
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      num[i] = {d_mid.abs_a[i], {FRAC_BITS{1'b0}}} + NW'(pdv_nxt >> 1);
      pm_nxt.ovf[i] = (WORD_BITS'(num[i][NW-1:WORD_BITS]) >= pdv_nxt);
      prem_nxt[i] = WORD_BITS'(num[i][NW-1:WORD_BITS]);
      plo_nxt[i] = num[i][WORD_BITS-1:0];
    end
  end

  // stage inputs
  always_comb begin
    dv_p[0] = pdv_r;
    for (int i = 0; i < 3; i++) begin
      rem_p[0][i] = prem_r[i];
      lo_p[0][i]  = plo_r[i];
    end
    for (int g = 1; g < WORD_BITS; g++) begin
      dv_p[g] = dv_r[g-1];
      for (int i = 0; i < 3; i++) begin
        rem_p[g][i] = rem_r[g-1][i];
        lo_p[g][i]  = lo_r[g-1][i];
      end
    end
  end

  // restoring step per lane
  always_comb begin
    for (int g = 0; g < WORD_BITS; g++) begin
      for (int i = 0; i < 3; i++) begin
        cur[g][i] = {rem_p[g][i], lo_p[g][i][WORD_BITS-1]};
        if (cur[g][i] >= {1'b0, dv_p[g]}) begin
          rem_nxt[g][i] = WORD_BITS'(cur[g][i] - {1'b0, dv_p[g]});
          lo_nxt[g][i]  = {lo_p[g][i][WORD_BITS-2:0], 1'b1};
        end else begin
          rem_nxt[g][i] = cur[g][i][WORD_BITS-1:0];
          lo_nxt[g][i]  = {lo_p[g][i][WORD_BITS-2:0], 1'b0};
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      for (int g = 0; g < WORD_BITS; g++) vld_r[g] <= 1'b0;
    end else if (en) begin
      pv_r <= d_valid;
      vld_r[0] <= pv_r;
      for (int g = 1; g < WORD_BITS; g++) vld_r[g] <= vld_r[g-1];
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      pm_r <= pm_nxt;
      pdv_r <= pdv_nxt;
      for (int i = 0; i < 3; i++) begin
        prem_r[i] <= prem_nxt[i];
        plo_r[i]  <= plo_nxt[i];
      end
      mid_r[0] <= pm_r;
      for (int g = 1; g < WORD_BITS; g++) mid_r[g] <= mid_r[g-1];
      for (int g = 0; g < WORD_BITS; g++) begin
        dv_r[g] <= dv_p[g];
        for (int i = 0; i < 3; i++) begin
          rem_r[g][i] <= rem_nxt[g][i];
          lo_r[g][i]  <= lo_nxt[g][i];
        end
      end
    end
  end

  assign o_valid = vld_r[WORD_BITS-1];
  assign o_mid   = mid_r[WORD_BITS-1];
  always_comb begin
    for (int i = 0; i < 3; i++) o_quo[i] = lo_r[WORD_BITS-1][i];
  end

endmodule
